[src/stack_slot_span_allocator_unit_defines.svh]
// Assertion macros shared by the span allocator RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef STACK_SLOT_SPAN_ALLOCATOR_UNIT_DEFINES_SVH
`define STACK_SLOT_SPAN_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSSA_ASSERT_HOLD(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("span allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSSA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("span allocator check failed");

`endif

[src/sssa_pkg.sv]
// Shared types and constants of the stack slot span allocator.
// No dependencies; imported by every module of the block.
package sssa_pkg;

    // Fixed field widths.
    localparam int SIZE_W = 8;
    localparam int SLOT_W = 12;
    localparam int STAT_W = 2;
    // A rounded request stays below 512 bytes (255 plus at most GRANULE_BYTES - 1).
    localparam int NEED_W = 9;

    // Parameter defaults.
    localparam int SPAN_BYTES_DEF    = 64;
    localparam int GRANULE_BYTES_DEF = 4;
    localparam int POINTER_BYTES_DEF = 8;
    localparam int SLOT_BASE_DEF     = 0;
    localparam int MAX_SPANS_DEF     = 32;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_TOO_BIG = 2'd1,
        STAT_LIMIT   = 2'd2
    } sssa_stat_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RND,
        ST_NEED,
        ST_LOAD,
        ST_WALK,
        ST_FIT,
        ST_DONE
    } sssa_state_t;

    // Conditions reported by the datapath to the sequencer.
    typedef struct packed {
        logic in_fire;
        logic oversize;
        logic walk_more;
        logic need_new;
        logic at_limit;
        logic out_free;
    } sssa_flags_t;

    // Controls driven by the sequencer into the datapath.
    typedef struct packed {
        logic       in_ready;
        logic       load_walk;
        logic       walk_step;
        logic       commit;
        logic       res_load;
        sssa_stat_t res_stat;
        logic       out_load;
    } sssa_ctrl_t;

endpackage

[src/sssa_round.sv]
// Two-stage unit that rounds a plain request size up to the granule.
// Depends on sssa_pkg; the quotient uses a constant reciprocal multiply.
module sssa_round #(
    parameter int GRANULE_BYTES = sssa_pkg::GRANULE_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic [sssa_pkg::SIZE_W-1:0] size_i,
    output logic [sssa_pkg::NEED_W-1:0] need_o
);
    import sssa_pkg::*;

    // Reciprocal with 24 fractional bits is exact for dividends below 4096.
    localparam int RSH    = 24;
    localparam int RECIP  = ((1 << RSH) + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int RCP_W  = RSH + 1;
    localparam int PROD_W = NEED_W + RCP_W;
    localparam int GRAN_W = $clog2(GRANULE_BYTES + 1);
    localparam int MUL_W  = NEED_W + GRAN_W;

    logic [NEED_W-1:0] dividend;
    logic [PROD_W-1:0] quot_prod;
    logic [NEED_W-1:0] quot_next;
    logic [NEED_W-1:0] quot_reg;
    logic [MUL_W-1:0]  need_prod;
    logic [NEED_W-1:0] need_next;
    logic [NEED_W-1:0] need_reg;

    // First stage: ceiling quotient by the granule.
    always_comb begin
        dividend  = NEED_W'(size_i) + NEED_W'(GRANULE_BYTES - 1);
        quot_prod = PROD_W'(dividend) * PROD_W'(RECIP);
        quot_next = quot_prod[RSH +: NEED_W];
    end

    // Second stage: scale the quotient back to bytes.
    always_comb begin
        need_prod = MUL_W'(quot_reg) * MUL_W'(GRANULE_BYTES);
        need_next = need_prod[NEED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        need_reg <= need_next;
    end

    assign need_o = need_reg;

endmodule

[src/sssa_ctrl.sv]
// Sequencer of the span allocator: accept, round, walk spans, fit, deliver.
// Depends on sssa_pkg for the state type and the flag and control structs.
module sssa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sssa_pkg::sssa_flags_t flags_i,
    output sssa_pkg::sssa_ctrl_t  ctrl_o
);
    import sssa_pkg::*;

    sssa_state_t state_reg;
    sssa_state_t state_next;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (flags_i.in_fire) begin
                    state_next = ST_RND;
                end
            end
            ST_RND:  state_next = ST_NEED;
            ST_NEED: state_next = ST_LOAD;
            ST_LOAD: begin
                if (flags_i.oversize) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!flags_i.walk_more) begin
                    state_next = ST_FIT;
                end
            end
            ST_FIT:  state_next = ST_DONE;
            ST_DONE: begin
                if (flags_i.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output decode.
    always_comb begin
        ctrl_o          = '0;
        ctrl_o.res_stat = STAT_OK;
        case (state_reg)
            ST_IDLE: ctrl_o.in_ready = 1'b1;
            ST_LOAD: begin
                if (flags_i.oversize) begin
                    ctrl_o.res_load = 1'b1;
                    ctrl_o.res_stat = STAT_TOO_BIG;
                end else begin
                    ctrl_o.load_walk = 1'b1;
                end
            end
            ST_WALK: ctrl_o.walk_step = flags_i.walk_more;
            ST_FIT: begin
                ctrl_o.res_load = 1'b1;
                if (flags_i.need_new && flags_i.at_limit) begin
                    ctrl_o.res_stat = STAT_LIMIT;
                end else begin
                    ctrl_o.commit = 1'b1;
                end
            end
            ST_DONE: ctrl_o.out_load = flags_i.out_free;
            default: ctrl_o = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/stack_slot_span_allocator_unit.sv]
// Top level of the stack slot span allocator: pointers, span map, walker, output.
// Depends on sssa_pkg, sssa_round, sssa_ctrl and the assertion macro header.
`include "stack_slot_span_allocator_unit_defines.svh"

// Reserves frame slots from two bump pointers, one for plain data and one for
// references, over storage cut into SPAN_BYTES spans. Each request is one
// transfer on the s_ side and yields exactly one transfer on the m_ side with
// the end offset of the slot plus SLOT_BASE and a status. One request is in
// work at a time: s_tready is high only while the sequencer is idle. A request
// passes through RND, NEED, LOAD, WALK, FIT and DONE before the next possible
// input transfer, and stays in WALK while the pointer walks past spans of the
// other kind; the walker advances one span per cycle. An oversized request goes
// from LOAD straight to DONE. RND and NEED cover the registered reciprocal
// multiply that rounds a plain size up to the granule. The result sits in an
// output register, so the sequencer returns to idle once it is loaded there.
module stack_slot_span_allocator_unit #(
    parameter int SPAN_BYTES    = sssa_pkg::SPAN_BYTES_DEF,
    parameter int GRANULE_BYTES = sssa_pkg::GRANULE_BYTES_DEF,
    parameter int POINTER_BYTES = sssa_pkg::POINTER_BYTES_DEF,
    parameter int SLOT_BASE     = sssa_pkg::SLOT_BASE_DEF,
    parameter int MAX_SPANS     = sssa_pkg::MAX_SPANS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] size
    input  logic        s_tuser,   // [0] op (1 = reference slot)
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] slot_offset, [15:12] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import sssa_pkg::*;

    localparam int LVL_W = $clog2(MAX_SPANS * SPAN_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_SPANS + 1);
    localparam int IDX_W = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int OFF_W = $clog2(SPAN_BYTES + 1);
    localparam int SUM_W = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
    localparam int RES_W = ((LVL_W > SLOT_W) ? LVL_W : SLOT_W) + 1;
    localparam logic [SUM_W-1:0] SPAN_S = SUM_W'(SPAN_BYTES);
    localparam logic [LVL_W-1:0] SPAN_L = LVL_W'(SPAN_BYTES);

    sssa_flags_t flags;
    sssa_ctrl_t  ctl;

    // Request capture.
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [NEED_W-1:0] rnd_need;
    logic [NEED_W-1:0] need;

    // Allocator state: each pointer kept as level, span index and offset.
    logic [LVL_W-1:0]     plain_lvl_reg;
    logic [CNT_W-1:0]     plain_idx_reg;
    logic [OFF_W-1:0]     plain_off_reg;
    logic [LVL_W-1:0]     ref_lvl_reg;
    logic [CNT_W-1:0]     ref_idx_reg;
    logic [OFF_W-1:0]     ref_off_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [LVL_W-1:0]     end_reg;
    logic [MAX_SPANS-1:0] map_reg;

    // Span walker.
    logic [LVL_W-1:0] w_lvl_reg;
    logic [CNT_W-1:0] w_idx_reg;
    logic [OFF_W-1:0] w_off_reg;

    // Working span count and end, with the first span opened when none is.
    logic [CNT_W-1:0] wc;
    logic [LVL_W-1:0] we;

    // Commit values.
    logic [LVL_W-1:0] base_lvl;
    logic [CNT_W-1:0] base_idx;
    logic [OFF_W-1:0] base_off;
    logic [SUM_W-1:0] fit_sum;
    logic [SUM_W-1:0] off_sum;
    logic             wrap;
    logic [LVL_W-1:0] lvl_next;
    logic [CNT_W-1:0] idx_next;
    logic [OFF_W-1:0] off_next;
    logic [CNT_W-1:0] count_next;
    logic [LVL_W-1:0] end_next;
    logic [RES_W-1:0] slot_sum;

    // Result and output registers.
    logic [SLOT_W-1:0] res_slot_reg;
    sssa_stat_t        res_stat_reg;
    logic              m_valid_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    sssa_stat_t        m_stat_reg;

    sssa_round #(
        .GRANULE_BYTES(GRANULE_BYTES)
    ) u_round (
        .aclk  (aclk),
        .size_i(size_reg),
        .need_o(rnd_need)
    );

    sssa_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .flags_i(flags),
        .ctrl_o (ctl)
    );

    // Request size in bytes and the working span bounds.
    always_comb begin
        need = op_reg ? NEED_W'(POINTER_BYTES) : rnd_need;
        wc   = (count_reg == '0) ? CNT_W'(1) : count_reg;
        we   = (count_reg == '0) ? SPAN_L : end_reg;
    end

    // Fit check and the pointer values written on commit.
    always_comb begin
        fit_sum    = SUM_W'(w_off_reg) + SUM_W'(need);
        base_lvl   = flags.need_new ? we : w_lvl_reg;
        base_idx   = flags.need_new ? wc : w_idx_reg;
        base_off   = flags.need_new ? '0 : w_off_reg;
        off_sum    = SUM_W'(base_off) + SUM_W'(need);
        wrap       = (off_sum == SPAN_S);
        lvl_next   = base_lvl + LVL_W'(need);
        idx_next   = base_idx + CNT_W'(wrap);
        off_next   = wrap ? '0 : off_sum[OFF_W-1:0];
        count_next = wc + CNT_W'(flags.need_new);
        end_next   = flags.need_new ? (we + SPAN_L) : we;
        slot_sum   = RES_W'(lvl_next) + RES_W'(SLOT_BASE);
    end

    // Conditions for the sequencer.
    always_comb begin
        flags.in_fire   = s_tvalid && ctl.in_ready;
        flags.oversize  = SUM_W'(need) > SPAN_S;
        flags.walk_more = (w_idx_reg < wc) && (map_reg[w_idx_reg[IDX_W-1:0]] != op_reg);
        flags.need_new  = (w_idx_reg >= wc) || (fit_sum > SPAN_S);
        flags.at_limit  = wc >= CNT_W'(MAX_SPANS);
        flags.out_free  = !m_valid_reg || m_tready;
    end

    // Request capture on the input transfer.
    always_ff @(posedge aclk) begin
        if (flags.in_fire) begin
            op_reg   <= s_tuser;
            size_reg <= s_tdata;
        end
    end

    // Span walker: load from the selected pointer, then step one span a cycle.
    always_ff @(posedge aclk) begin
        if (ctl.load_walk) begin
            w_lvl_reg <= op_reg ? ref_lvl_reg : plain_lvl_reg;
            w_idx_reg <= op_reg ? ref_idx_reg : plain_idx_reg;
            w_off_reg <= op_reg ? ref_off_reg : plain_off_reg;
        end else if (ctl.walk_step) begin
            w_lvl_reg <= w_lvl_reg + SPAN_L;
            w_idx_reg <= w_idx_reg + CNT_W'(1);
        end
    end

    // Allocator state, updated only by a successful request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plain_lvl_reg <= '0;
            plain_idx_reg <= '0;
            plain_off_reg <= '0;
            ref_lvl_reg   <= '0;
            ref_idx_reg   <= '0;
            ref_off_reg   <= '0;
            count_reg     <= '0;
            end_reg       <= '0;
            map_reg       <= '0;
        end else if (ctl.commit) begin
            if (op_reg) begin
                ref_lvl_reg <= lvl_next;
                ref_idx_reg <= idx_next;
                ref_off_reg <= off_next;
            end else begin
                plain_lvl_reg <= lvl_next;
                plain_idx_reg <= idx_next;
                plain_off_reg <= off_next;
            end
            count_reg <= count_next;
            end_reg   <= end_next;
            if (flags.need_new) begin
                map_reg[wc[IDX_W-1:0]] <= op_reg;
            end
        end
    end

    // Result holding register; a failed request reports offset zero.
    always_ff @(posedge aclk) begin
        if (ctl.res_load) begin
            res_stat_reg <= ctl.res_stat;
            res_slot_reg <= ctl.commit ? slot_sum[SLOT_W-1:0] : '0;
        end
    end

    // Output register of the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_slot_reg <= res_slot_reg;
            m_stat_reg <= res_stat_reg;
        end
    end

    assign s_tready = ctl.in_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - SLOT_W){1'b0}}, m_slot_reg};
    assign m_tuser  = m_stat_reg;

    // The span count never passes the limit.
    `SSSA_ASSERT_HOLD(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_SPANS))
    // Both pointers stay within the spans opened so far.
    `SSSA_ASSERT_HOLD(a_idx_open, aclk, aresetn, 1'b1, (plain_idx_reg <= count_reg) && (ref_idx_reg <= count_reg))
    // A request is not followed by another input transfer in the next cycle.
    `SSSA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A failed request leaves the allocator state untouched.
    `SSSA_ASSERT_NEXT(a_fail_keeps, aclk, aresetn, ctl.res_load && !ctl.commit, $stable(count_reg) && $stable(map_reg))

endmodule
